### rtl/krl_pkg.sv
// Shared types and constants of the keyed fixed-window rate limiter.
package krl_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int ID_W       = 64;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_SCOPE  = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;
    localparam logic [1:0] REG_WINDOW = 2'd3;

    typedef enum logic [1:0] {
        SCOPE_GLOBAL   = 2'd0,
        SCOPE_USER     = 2'd1,
        SCOPE_CLIENT   = 2'd2,
        SCOPE_TEMPLATE = 2'd3
    } t_scope;

    typedef struct packed {
        logic                enabled;
        t_scope              scope;
        logic [COUNT_W-1:0]  max_per_window;
        logic [COUNT_W-1:0]  window_seconds;
    } t_cfg;

    localparam logic [COUNT_W-1:0] MAX_RESET    = 16'd60;
    localparam logic [COUNT_W-1:0] WINDOW_RESET = 16'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF,
        ST_WIN,
        ST_LIM,
        ST_INC,
        ST_RESP
    } t_state;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } t_alu_op;

    typedef struct packed {
        logic              carry;
        logic [TIME_W-1:0] value;
    } t_alu_res;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } t_scan_status;

endpackage

### rtl/krl_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface krl_req_if;
    logic                        valid;
    logic                        ready;
    logic [krl_pkg::TIME_W-1:0]  now_seconds;
    logic [krl_pkg::ID_W-1:0]    user_id;
    logic                        user_present;
    logic [krl_pkg::ID_W-1:0]    client_addr;
    logic                        client_present;
    logic [krl_pkg::ID_W-1:0]    template_id;
    logic                        template_present;

    modport source (
        output valid, now_seconds, user_id, user_present, client_addr, client_present,
               template_id, template_present,
        input  ready
    );
    modport sink (
        input  valid, now_seconds, user_id, user_present, client_addr, client_present,
               template_id, template_present,
        output ready
    );
endinterface

### rtl/krl_rsp_if.sv
// Response channel: valid/ready handshake with the verdict payload.
interface krl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        throttled;
    logic [krl_pkg::COUNT_W-1:0] bucket_count;
    logic                        fail_open;

    modport source (
        output valid, throttled, bucket_count, fail_open,
        input  ready
    );
    modport sink (
        input  valid, throttled, bucket_count, fail_open,
        output ready
    );
endinterface

### rtl/krl_apb_regs.sv
// APB configuration registers of the rate limiter.
module krl_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [krl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [krl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [krl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output krl_pkg::t_cfg                   o_cfg
);

    krl_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled        <= 1'b0;
            r_cfg.scope          <= krl_pkg::SCOPE_GLOBAL;
            r_cfg.max_per_window <= krl_pkg::MAX_RESET;
            r_cfg.window_seconds <= krl_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                krl_pkg::REG_ENABLE: r_cfg.enabled        <= pwdata[0];
                krl_pkg::REG_SCOPE:  r_cfg.scope          <= krl_pkg::t_scope'(pwdata[1:0]);
                krl_pkg::REG_MAX:    r_cfg.max_per_window <= pwdata[krl_pkg::COUNT_W-1:0];
                krl_pkg::REG_WINDOW: r_cfg.window_seconds <= pwdata[krl_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            krl_pkg::REG_ENABLE: prdata = krl_pkg::APB_DATA_W'(r_cfg.enabled);
            krl_pkg::REG_SCOPE:  prdata = krl_pkg::APB_DATA_W'(r_cfg.scope);
            krl_pkg::REG_MAX:    prdata = krl_pkg::APB_DATA_W'(r_cfg.max_per_window);
            krl_pkg::REG_WINDOW: prdata = krl_pkg::APB_DATA_W'(r_cfg.window_seconds);
            default:             prdata = '0;
        endcase
    end

endmodule

### rtl/krl_alu.sv
// Shared 32-bit add/subtract unit; carry out doubles as the unsigned a >= b flag.
module krl_alu (
    input  krl_pkg::t_alu_op                i_op,
    input  logic [krl_pkg::TIME_W-1:0]      i_a,
    input  logic [krl_pkg::TIME_W-1:0]      i_b,
    output krl_pkg::t_alu_res               o_res
);

    logic [krl_pkg::TIME_W-1:0] b_eff;
    logic                       cin;
    logic [krl_pkg::TIME_W:0]   sum;

    always_comb begin
        case (i_op)
            krl_pkg::ALU_SUB: begin
                b_eff = ~i_b;
                cin   = 1'b1;
            end
            default: begin
                b_eff = i_b;
                cin   = 1'b0;
            end
        endcase
        sum = {1'b0, i_a} + {1'b0, b_eff} + {{krl_pkg::TIME_W{1'b0}}, cin};
    end

    assign o_res.carry = sum[krl_pkg::TIME_W];
    assign o_res.value = sum[krl_pkg::TIME_W-1:0];

endmodule

### rtl/krl_bucket_table.sv
// Keyed bucket memory with fill count and a one-entry-per-cycle key scan.
module krl_bucket_table #(
    parameter  int ENTRIES  = 16,
    parameter  int KEY_BITS = 64,
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W    = $clog2(ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_scan,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic                          i_wr_en,
    input  logic                          i_wr_new,
    input  logic [IDX_W-1:0]              i_wr_slot,
    input  logic [KEY_BITS-1:0]           i_wr_key,
    input  logic [krl_pkg::TIME_W-1:0]    i_wr_start,
    input  logic [krl_pkg::COUNT_W-1:0]   i_wr_count,
    output krl_pkg::t_scan_status         o_status,
    output logic [IDX_W-1:0]              o_slot,
    output logic [IDX_W-1:0]              o_free_slot,
    output logic [krl_pkg::TIME_W-1:0]    o_start,
    output logic [krl_pkg::COUNT_W-1:0]   o_count
);

    localparam int EW = KEY_BITS + krl_pkg::TIME_W + krl_pkg::COUNT_W;

    // entry layout: {key, window start, count}
    logic [EW-1:0]                r_mem [ENTRIES];
    logic [EW-1:0]                r_rd_data;
    logic [IDX_W-1:0]             r_rd_idx;
    logic                         r_rd_vld;
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_busy;
    logic                         r_done;
    logic                         r_hit;
    logic [IDX_W-1:0]             r_slot;
    logic [krl_pkg::TIME_W-1:0]   r_start;
    logic [krl_pkg::COUNT_W-1:0]  r_count;
    logic                         issue;
    logic                         match;

    // entries are claimed in order and never freed: valid == index below fill
    assign issue = r_busy && (r_idx < r_fill);
    assign match = r_rd_vld && (r_rd_data[EW-1 -: KEY_BITS] == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_fill   <= '0;
            r_idx    <= '0;
        end else begin
            r_done   <= r_busy && !i_scan && (match || !issue);
            r_rd_vld <= !i_scan && issue && !match;
            if (i_scan) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (match || !issue) begin
                    // hit, or the last issued read came back without one
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_wr_en && i_wr_new) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
            r_rd_idx  <= r_idx[IDX_W-1:0];
        end
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= {i_wr_key, i_wr_start, i_wr_count};
        end
        if (r_busy && !i_scan) begin
            r_hit   <= match;
            r_slot  <= r_rd_idx;
            r_start <= r_rd_data[krl_pkg::COUNT_W +: krl_pkg::TIME_W];
            r_count <= r_rd_data[krl_pkg::COUNT_W-1:0];
        end
    end

    assign o_status.done = r_done;
    assign o_status.hit  = r_hit;
    assign o_status.full = (r_fill == CNT_W'(ENTRIES));
    assign o_slot        = r_slot;
    assign o_free_slot   = r_fill[IDX_W-1:0];
    assign o_start       = r_start;
    assign o_count       = r_count;

endmodule

### rtl/keyed_fixed_window_rate_limiter_unit.sv
// Top level of the keyed fixed-window rate limiter: sequencer, global bucket, result register.
//
// Each request transaction selects a bucket by the key_scope register (global, user, client
// address or template; an absent key falls back to the global bucket), restarts the bucket's
// window when it has expired, then either throttles the request or counts it. One request is
// in flight at a time: the request channel is ready only while the sequencer is idle. A keyed
// request scans the bucket memory one entry per cycle through its single read port and then
// makes four passes through one shared 32-bit add/subtract unit (elapsed time, window compare,
// limit compare, increment). A global-bucket request skips the scan and makes the same four
// passes; a bypassed one (limiter off, limit or window zero) goes straight to the response
// with an allow and a zero count, and a keyed miss on a full table answers with fail_open set
// and leaves all buckets untouched. The result then holds until the response transaction
// completes. Buckets are claimed in order and never released, so a fill count replaces
// per-entry valid bits and reset needs no clearing pass.
// Configuration is written through the APB port at byte address 4 * register index.
module keyed_fixed_window_rate_limiter_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    krl_req_if.sink                         i_req,
    krl_rsp_if.source                       o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [krl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [krl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [krl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PAD_W = krl_pkg::TIME_W - krl_pkg::COUNT_W;

    krl_pkg::t_cfg         cfg;
    krl_pkg::t_scan_status tbl_status;
    krl_pkg::t_alu_op      alu_op;
    krl_pkg::t_alu_res     alu_res;
    krl_pkg::t_state       r_state, n_state;

    logic [krl_pkg::TIME_W-1:0]   alu_a, alu_b;
    logic [IDX_W-1:0]             tbl_slot, tbl_free_slot;
    logic [krl_pkg::TIME_W-1:0]   tbl_start;
    logic [krl_pkg::COUNT_W-1:0]  tbl_count;

    logic                         accept;
    logic                         bypass;
    logic                         sel_keyed;
    logic [KEY_BITS-1:0]          sel_key;
    logic                         scan;
    logic                         wr_en;
    logic [krl_pkg::COUNT_W-1:0]  final_count;

    // request context
    logic [krl_pkg::TIME_W-1:0]   r_now, n_now;
    logic [KEY_BITS-1:0]          r_key, n_key;
    logic                         r_glob, n_glob;
    logic                         r_new, n_new;
    logic [IDX_W-1:0]             r_slot, n_slot;
    logic [krl_pkg::TIME_W-1:0]   r_start, n_start;
    logic [krl_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [krl_pkg::TIME_W-1:0]   r_diff, n_diff;
    logic                         r_thr, n_thr;

    // result register
    logic                         r_out_thr, n_out_thr;
    logic [krl_pkg::COUNT_W-1:0]  r_out_count, n_out_count;
    logic                         r_out_fail, n_out_fail;

    // global bucket
    logic                         r_gvalid, n_gvalid;
    logic [krl_pkg::TIME_W-1:0]   r_gstart, n_gstart;
    logic [krl_pkg::COUNT_W-1:0]  r_gcount, n_gcount;

    krl_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    krl_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    krl_bucket_table #(
        .ENTRIES  (TABLE_ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan      (scan),
        .i_key       (r_key),
        .i_wr_en     (wr_en),
        .i_wr_new    (r_new),
        .i_wr_slot   (r_slot),
        .i_wr_key    (r_key),
        .i_wr_start  (r_start),
        .i_wr_count  (final_count),
        .o_status    (tbl_status),
        .o_slot      (tbl_slot),
        .o_free_slot (tbl_free_slot),
        .o_start     (tbl_start),
        .o_count     (tbl_count)
    );

    assign i_req.ready = (r_state == krl_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign bypass = !cfg.enabled || (cfg.max_per_window == '0) || (cfg.window_seconds == '0);

    // bucket key selection; only the low KEY_BITS take part in matching
    always_comb begin
        sel_keyed = 1'b0;
        sel_key   = '0;
        case (cfg.scope)
            krl_pkg::SCOPE_USER: begin
                if (i_req.user_present) begin
                    sel_keyed = 1'b1;
                    sel_key   = i_req.user_id[KEY_BITS-1:0];
                end
            end
            krl_pkg::SCOPE_CLIENT: begin
                if (i_req.client_present) begin
                    sel_keyed = 1'b1;
                    sel_key   = i_req.client_addr[KEY_BITS-1:0];
                end
            end
            krl_pkg::SCOPE_TEMPLATE: begin
                if (i_req.template_present) begin
                    sel_keyed = 1'b1;
                    sel_key   = i_req.template_id[KEY_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= krl_pkg::ST_IDLE;
            r_gvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gvalid <= n_gvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_key       <= n_key;
        r_glob      <= n_glob;
        r_new       <= n_new;
        r_slot      <= n_slot;
        r_start     <= n_start;
        r_count     <= n_count;
        r_diff      <= n_diff;
        r_thr       <= n_thr;
        r_out_thr   <= n_out_thr;
        r_out_count <= n_out_count;
        r_out_fail  <= n_out_fail;
        r_gstart    <= n_gstart;
        r_gcount    <= n_gcount;
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_key       = r_key;
        n_glob      = r_glob;
        n_new       = r_new;
        n_slot      = r_slot;
        n_start     = r_start;
        n_count     = r_count;
        n_diff      = r_diff;
        n_thr       = r_thr;
        n_out_thr   = r_out_thr;
        n_out_count = r_out_count;
        n_out_fail  = r_out_fail;
        n_gvalid    = r_gvalid;
        n_gstart    = r_gstart;
        n_gcount    = r_gcount;
        alu_op      = krl_pkg::ALU_SUB;
        alu_a       = r_now;
        alu_b       = r_start;
        scan        = 1'b0;
        wr_en       = 1'b0;
        final_count = r_count;

        case (r_state)
            krl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_now  = i_req.now_seconds;
                    n_key  = sel_key;
                    n_glob = !sel_keyed;
                    n_new  = 1'b0;
                    n_thr  = 1'b0;
                    if (bypass) begin
                        n_out_thr   = 1'b0;
                        n_out_count = '0;
                        n_out_fail  = 1'b0;
                        n_state     = krl_pkg::ST_RESP;
                    end else if (!sel_keyed) begin
                        // first global request opens its window now
                        if (r_gvalid) begin
                            n_start = r_gstart;
                            n_count = r_gcount;
                        end else begin
                            n_start = i_req.now_seconds;
                            n_count = '0;
                        end
                        n_state = krl_pkg::ST_DIFF;
                    end else begin
                        scan    = 1'b1;
                        n_state = krl_pkg::ST_SCAN;
                    end
                end
            end
            krl_pkg::ST_SCAN: begin
                if (tbl_status.done) begin
                    if (tbl_status.hit) begin
                        n_slot  = tbl_slot;
                        n_start = tbl_start;
                        n_count = tbl_count;
                        n_state = krl_pkg::ST_DIFF;
                    end else if (tbl_status.full) begin
                        // fail open: allow, flag, leave all buckets untouched
                        n_out_thr   = 1'b0;
                        n_out_count = '0;
                        n_out_fail  = 1'b1;
                        n_state     = krl_pkg::ST_RESP;
                    end else begin
                        // claim the lowest free entry with a fresh window
                        n_slot  = tbl_free_slot;
                        n_start = r_now;
                        n_count = '0;
                        n_new   = 1'b1;
                        n_state = krl_pkg::ST_DIFF;
                    end
                end
            end
            krl_pkg::ST_DIFF: begin
                // elapsed time, modulo 2^32
                alu_a   = r_now;
                alu_b   = r_start;
                n_diff  = alu_res.value;
                n_state = krl_pkg::ST_WIN;
            end
            krl_pkg::ST_WIN: begin
                alu_a = r_diff;
                alu_b = {{PAD_W{1'b0}}, cfg.window_seconds};
                if (alu_res.carry) begin
                    // window expired: restart at now
                    n_start = r_now;
                    n_count = '0;
                end
                n_state = krl_pkg::ST_LIM;
            end
            krl_pkg::ST_LIM: begin
                alu_a   = {{PAD_W{1'b0}}, r_count};
                alu_b   = {{PAD_W{1'b0}}, cfg.max_per_window};
                n_thr   = alu_res.carry;
                n_state = krl_pkg::ST_INC;
            end
            krl_pkg::ST_INC: begin
                alu_op      = krl_pkg::ALU_ADD;
                alu_a       = {{PAD_W{1'b0}}, r_count};
                alu_b       = krl_pkg::TIME_W'(1);
                final_count = r_thr ? r_count : alu_res.value[krl_pkg::COUNT_W-1:0];
                wr_en       = !r_glob;
                if (r_glob) begin
                    n_gvalid = 1'b1;
                    n_gstart = r_start;
                    n_gcount = final_count;
                end
                n_out_thr   = r_thr;
                n_out_count = final_count;
                n_out_fail  = 1'b0;
                n_state     = krl_pkg::ST_RESP;
            end
            krl_pkg::ST_RESP: begin
                if (o_rsp.ready) begin
                    n_state = krl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = krl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid        = (r_state == krl_pkg::ST_RESP);
    assign o_rsp.throttled    = r_out_thr;
    assign o_rsp.bucket_count = r_out_count;
    assign o_rsp.fail_open    = r_out_fail;

    // a fail-open verdict is always an allow with a zero count
    a_fail_open_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fail_open) |-> (!o_rsp.throttled && o_rsp.bucket_count == '0))
        else $error("fail_open result carries throttle or count");

    // one request at a time: no acceptance right after an acceptance
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request accepted while previous one in flight");

    // the table only reports scan completion while the sequencer waits for it
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_status.done |-> (r_state == krl_pkg::ST_SCAN))
        else $error("scan completion outside scan state");

    // a table write only follows a completed lookup of a keyed request
    a_write_keyed_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (!r_glob && $past(r_state) == krl_pkg::ST_LIM))
        else $error("bucket write outside keyed update");

endmodule

### verif/testbench.sv
// Self-checking testbench for the keyed fixed-window rate limiter: directed rows, then random traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_ENTRIES = 16;
    // The shadow bucket arrays carry one extra entry at the end for the global bucket.
    localparam int GLOBAL_SLOT   = TABLE_ENTRIES;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    // Overall cycle budget of the whole run; past it the watchdog ends the run with an error.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 168;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int MAX_PRINTS    = 100;
    localparam logic [krl_pkg::ID_W-1:0] ID_ONES = '1;
    localparam logic [krl_pkg::ID_W-1:0] ID_MARK = 64'h0123_4567_89AB_CDEF;

    typedef struct packed {
        logic                        throttled;
        logic [krl_pkg::COUNT_W-1:0] count;
        logic                        fail_open;
    } t_verdict;

    typedef struct packed {
        logic [krl_pkg::TIME_W-1:0] now;
        logic [krl_pkg::ID_W-1:0]   user_id;
        logic                       user_present;
        logic [krl_pkg::ID_W-1:0]   client_addr;
        logic                       client_present;
        logic [krl_pkg::ID_W-1:0]   template_id;
        logic                       template_present;
    } t_request;

    typedef enum bit { ROW_CFG, ROW_REQ } t_row_kind;

    // One row of the directed part: a register write or a request. A request row
    // can carry a hand-written verdict; otherwise the predictor supplies it.
    typedef struct {
        t_row_kind                      kind;
        logic [1:0]                     reg_idx;
        logic [krl_pkg::APB_DATA_W-1:0] reg_val;
        t_request                       rq;
        bit                             typed;
        t_verdict                       want;
    } t_stim_row;

    localparam t_verdict V_BYPASS = '{1'b0, 16'd0, 1'b0};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [krl_pkg::CFG_ADDR_W-1:0] paddr;
    logic [krl_pkg::APB_DATA_W-1:0] pwdata;
    logic [krl_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    krl_req_if req_if ();
    krl_rsp_if rsp_if ();

    keyed_fixed_window_rate_limiter_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (krl_pkg::ID_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration and the bucket table.
    krl_pkg::t_cfg                cfg_shadow;
    logic                         bkt_valid [GLOBAL_SLOT+1];
    logic [krl_pkg::ID_W-1:0]     bkt_key   [GLOBAL_SLOT+1];
    logic [krl_pkg::TIME_W-1:0]   bkt_start [GLOBAL_SLOT+1];
    logic [krl_pkg::COUNT_W-1:0]  bkt_count [GLOBAL_SLOT+1];

    t_verdict                     verdict_q [$];      // verdicts still owed by the DUT, oldest first
    t_stim_row                    stim_rows [$];
    logic [krl_pkg::ID_W-1:0]     key_pool  [TABLE_ENTRIES];
    int                           hot_key;
    logic [krl_pkg::TIME_W-1:0]   clock_s;            // running time base of the random traffic
    bit                           calm;               // no idling on either side while set
    int                           err_count;
    int                           cycle_count;
    t_verdict                     seen;
    t_verdict                     owed;

    always #CLK_HALF i_clk = ~i_clk;

    // Window and limit rule on one shadow bucket; returns the throttle flag.
    function automatic logic count_in_window(input int slot,
                                             input logic [krl_pkg::TIME_W-1:0] now);
        logic [krl_pkg::TIME_W-1:0] elapsed;
        elapsed = now - bkt_start[slot];   // wraps modulo 2^32
        if (elapsed >= krl_pkg::TIME_W'(cfg_shadow.window_seconds)) begin
            bkt_start[slot] = now;
            bkt_count[slot] = '0;
        end
        if (bkt_count[slot] >= cfg_shadow.max_per_window) begin
            return 1'b1;
        end
        bkt_count[slot] = bkt_count[slot] + 1'b1;
        return 1'b0;
    endfunction

    // Predicts the verdict of one request and advances the shadow table.
    function automatic t_verdict judge_request(input t_request rq);
        t_verdict                 v;
        logic                     keyed;
        logic [krl_pkg::ID_W-1:0] key;
        int                       slot;
        int                       free_slot;
        v     = '0;
        keyed = 1'b0;
        key   = '0;
        if (!cfg_shadow.enabled || cfg_shadow.max_per_window == '0 ||
            cfg_shadow.window_seconds == '0) begin
            return v;
        end
        case (cfg_shadow.scope)
            krl_pkg::SCOPE_USER: begin
                keyed = rq.user_present;
                key   = rq.user_id;
            end
            krl_pkg::SCOPE_CLIENT: begin
                keyed = rq.client_present;
                key   = rq.client_addr;
            end
            krl_pkg::SCOPE_TEMPLATE: begin
                keyed = rq.template_present;
                key   = rq.template_id;
            end
            default: keyed = 1'b0;
        endcase
        if (!keyed) begin
            slot = GLOBAL_SLOT;
        end else begin
            slot      = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (bkt_valid[i]) begin
                    if (slot < 0 && bkt_key[i] == key) slot = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (slot < 0) begin
                // miss on a full table: let it through, touch nothing
                if (free_slot < 0) begin
                    v.fail_open = 1'b1;
                    return v;
                end
                slot          = free_slot;
                bkt_key[slot] = key;
            end
        end
        if (!bkt_valid[slot]) begin
            bkt_valid[slot] = 1'b1;
            bkt_start[slot] = rq.now;
            bkt_count[slot] = '0;
        end
        v.throttled = count_in_window(slot, rq.now);
        v.count     = bkt_count[slot];
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want_v,
                                   input longint unsigned got_v);
        if (err_count < MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: want 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        end
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly the current hot key, so buckets fill up and throttle; some pool keys,
    // and a few fresh identities that miss the table.
    function automatic logic [krl_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return key_pool[hot_key];
        if (r < 88) return key_pool[$urandom_range(0, TABLE_ENTRIES-1)];
        return {$urandom, $urandom};
    endfunction

    // APB write: setup, access, then psel and penable drop low again. Called at a falling edge.
    task automatic write_reg(input logic [1:0] idx,
                             input logic [krl_pkg::APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= krl_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            krl_pkg::REG_ENABLE: cfg_shadow.enabled        = val[0];
            krl_pkg::REG_SCOPE:  cfg_shadow.scope          = krl_pkg::t_scope'(val[1:0]);
            krl_pkg::REG_MAX:    cfg_shadow.max_per_window = val[krl_pkg::COUNT_W-1:0];
            krl_pkg::REG_WINDOW: cfg_shadow.window_seconds = val[krl_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every owed verdict has arrived.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (verdict_q.size() != 0);
    endtask

    // Send one request transaction; the verdict is predicted at acceptance.
    task automatic drive_req(input t_request rq, input int gap, input bit typed,
                             input t_verdict want);
        t_verdict v;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.now_seconds      <= rq.now;
        req_if.user_id          <= rq.user_id;
        req_if.user_present     <= rq.user_present;
        req_if.client_addr      <= rq.client_addr;
        req_if.client_present   <= rq.client_present;
        req_if.template_id      <= rq.template_id;
        req_if.template_present <= rq.template_present;
        req_if.valid            <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        v = judge_request(rq);
        if (typed) v = want;
        verdict_q.push_back(v);
        @(negedge i_clk);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [krl_pkg::APB_DATA_W-1:0] val);
        t_stim_row row;
        row         = '{kind: ROW_CFG, default: '0};
        row.reg_idx = idx;
        row.reg_val = val;
        stim_rows.push_back(row);
    endtask

    task automatic add_req(input logic [krl_pkg::TIME_W-1:0] now,
                           input logic [krl_pkg::ID_W-1:0] uid, input logic up,
                           input logic [krl_pkg::ID_W-1:0] caddr, input logic cp,
                           input logic [krl_pkg::ID_W-1:0] tid, input logic tp,
                           input bit typed, input t_verdict want);
        t_stim_row row;
        row       = '{kind: ROW_REQ, default: '0};
        row.rq    = '{now, uid, up, caddr, cp, tid, tp};
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // Response side: ready with random stalls, mostly short and a few long.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) < 65) begin
                rsp_if.ready <= 1'b1;
            end else begin
                stall_left   = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                           : $urandom_range(10, 40);
                rsp_if.ready <= 1'b0;
            end
        end
    end

    // Checker: every response transaction is matched against the oldest owed verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen = '{rsp_if.throttled, rsp_if.bucket_count, rsp_if.fail_open};
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with nothing outstanding", 0, seen);
            end else begin
                owed = verdict_q.pop_front();
                if (seen.throttled !== owed.throttled)
                    report_mismatch("throttled", owed.throttled, seen.throttled);
                if (seen.count !== owed.count)
                    report_mismatch("bucket_count", owed.count, seen.count);
                if (seen.fail_open !== owed.fail_open)
                    report_mismatch("fail_open", owed.fail_open, seen.fail_open);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d verdicts outstanding",
                 cycle_count, verdict_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_request                       rq;
        logic [krl_pkg::APB_DATA_W-1:0] en_v;
        logic [krl_pkg::APB_DATA_W-1:0] scope_v;
        logic [krl_pkg::APB_DATA_W-1:0] max_v;
        logic [krl_pkg::APB_DATA_W-1:0] win_v;
        int                             r;

        // Every input is known from time zero.
        i_clk                   = 1'b0;
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        req_if.valid            = 1'b0;
        req_if.now_seconds      = '0;
        req_if.user_id          = '0;
        req_if.user_present     = 1'b0;
        req_if.client_addr      = '0;
        req_if.client_present   = 1'b0;
        req_if.template_id      = '0;
        req_if.template_present = 1'b0;
        calm                    = 1'b0;
        err_count               = 0;
        hot_key                 = 0;
        clock_s                 = '0;

        cfg_shadow = '{1'b0, krl_pkg::SCOPE_GLOBAL, krl_pkg::MAX_RESET, krl_pkg::WINDOW_RESET};
        for (int i = 0; i <= GLOBAL_SLOT; i++) begin
            bkt_valid[i] = 1'b0;
            bkt_key[i]   = '0;
            bkt_start[i] = '0;
            bkt_count[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = ID_ONES;
        key_pool[2] = ID_MARK;
        for (int i = 3; i < TABLE_ENTRIES; i++) key_pool[i] = {$urandom, $urandom};

        // ---- directed rows ----
        // out of reset the limiter is off: everything bypasses, field extremes too
        add_req(32'd0, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, V_BYPASS);
        add_req('1, ID_ONES, 1'b1, ID_ONES, 1'b1, ID_ONES, 1'b1, 1'b1, V_BYPASS);
        // global scope with the reset limit and window (60 / 60)
        add_cfg(krl_pkg::REG_ENABLE, 32'd1);
        add_req(32'd100, ID_ONES, 1'b1, '0, 1'b1, '0, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0});
        add_req(32'd159, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b0});
        // elapsed equal to the window restarts it
        add_req(32'd160, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, '{1'b0, 16'd1, 1'b0});
        // count already at the limit: throttled, count unchanged
        add_cfg(krl_pkg::REG_MAX, 32'd1);
        add_req(32'd161, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b0});
        // zero limit, then zero window: bypass
        add_cfg(krl_pkg::REG_MAX, 32'd0);
        add_req(32'd162, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, V_BYPASS);
        add_cfg(krl_pkg::REG_MAX, 32'hFFFF);
        add_cfg(krl_pkg::REG_WINDOW, 32'd0);
        add_req(32'd163, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1, V_BYPASS);
        // user scope: new bucket, absent user falls back to global
        add_cfg(krl_pkg::REG_WINDOW, 32'hFFFF);
        add_cfg(krl_pkg::REG_SCOPE, 32'(krl_pkg::SCOPE_USER));
        add_req(32'd200, '0, 1'b1, ID_ONES, 1'b1, '0, 1'b0, 1'b1, '{1'b0, 16'd1, 1'b0});
        add_req(32'd201, ID_ONES, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0, '0);
        add_req(32'hFFFF_FFF0, ID_ONES, 1'b1, '0, 1'b0, '0, 1'b0, 1'b1,
                '{1'b0, 16'd1, 1'b0});
        // time wraps past zero inside the window
        add_req(32'd5, ID_ONES, 1'b1, '0, 1'b0, '0, 1'b0, 1'b0, '0);
        add_cfg(krl_pkg::REG_MAX, 32'd2);
        add_req(32'd6, ID_ONES, 1'b1, '0, 1'b0, '0, 1'b0, 1'b0, '0);
        add_cfg(krl_pkg::REG_WINDOW, 32'd1);
        add_req(32'd7, ID_ONES, 1'b1, '0, 1'b0, '0, 1'b0, 1'b0, '0);
        // client scope with the same key value as a user bucket shares that bucket
        add_cfg(krl_pkg::REG_SCOPE, 32'(krl_pkg::SCOPE_CLIENT));
        add_req(32'd300, ID_ONES, 1'b1, '0, 1'b1, '0, 1'b0, 1'b0, '0);
        add_req(32'd300, ID_ONES, 1'b1, '0, 1'b1, '0, 1'b0, 1'b0, '0);
        add_req(32'd300, ID_ONES, 1'b1, '0, 1'b1, '0, 1'b0, 1'b0, '0);
        // template scope: absent template goes global, present one claims a bucket
        add_cfg(krl_pkg::REG_SCOPE, 32'(krl_pkg::SCOPE_TEMPLATE));
        add_req(32'd301, ID_ONES, 1'b1, ID_ONES, 1'b1, ID_MARK, 1'b0, 1'b0, '0);
        add_req(32'd302, '0, 1'b0, '0, 1'b0, ID_MARK, 1'b1, 1'b0, '0);
        add_cfg(krl_pkg::REG_ENABLE, 32'd0);
        add_req(32'd303, '0, 1'b0, '0, 1'b0, ID_MARK, 1'b1, 1'b1, V_BYPASS);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end else begin
                drive_req(stim_rows[i].rq, pick_gap(), stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // ---- warm-up: every pool key ends up with a bucket, which fills the table ----
        settle();
        write_reg(krl_pkg::REG_ENABLE, 32'd1);
        write_reg(krl_pkg::REG_SCOPE, 32'(krl_pkg::SCOPE_USER));
        write_reg(krl_pkg::REG_MAX, 32'hFFFF);
        write_reg(krl_pkg::REG_WINDOW, 32'hFFFF);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            clock_s = clock_s + 1'b1;
            rq = '{clock_s, key_pool[k], 1'b1, {$urandom, $urandom}, 1'($urandom),
                   {$urandom, $urandom}, 1'($urandom)};
            drive_req(rq, pick_gap(), 1'b0, '0);
        end

        // ---- random phases, each with its own register setting ----
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            en_v    = 32'd1;
            scope_v = 32'($urandom_range(0, 3));
            case (phase)
                0: begin                        // largest limit and window
                    max_v = 32'hFFFF;
                    win_v = 32'hFFFF;
                end
                1: begin                        // smallest nonzero limit and window
                    max_v = 32'd1;
                    win_v = 32'd1;
                end
                default: begin
                    en_v = (phase == 2 || $urandom_range(0, 7) == 0) ? 32'd0 : 32'd1;
                    r = $urandom_range(0, 99);
                    max_v = (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFF : 32'($urandom_range(1, 6));
                    r = $urandom_range(0, 99);
                    win_v = (r < 5) ? 32'd0 : (r < 15) ? 32'hFFFF : 32'($urandom_range(1, 12));
                end
            endcase
            write_reg(krl_pkg::REG_ENABLE, en_v);
            write_reg(krl_pkg::REG_SCOPE, scope_v);
            write_reg(krl_pkg::REG_MAX, max_v);
            write_reg(krl_pkg::REG_WINDOW, win_v);
            calm = (phase == 3) || ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // now and then hold off until the DUT has answered everything
                if ($urandom_range(0, 49) == 0) settle();
                if ($urandom_range(0, 9) == 0) hot_key = $urandom_range(0, TABLE_ENTRIES-1);
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    clock_s = $urandom;         // jump anywhere on the time line
                end else if (r >= 5) begin
                    clock_s = clock_s + krl_pkg::TIME_W'($urandom_range(0, 2));
                end
                // r in [3,5): a stray timestamp that leaves the time base alone
                rq.now              = (r >= 3 && r < 5) ? krl_pkg::TIME_W'($urandom) : clock_s;
                rq.user_id          = pick_id();
                rq.user_present     = ($urandom_range(0, 9) != 0);
                rq.client_addr      = pick_id();
                rq.client_present   = ($urandom_range(0, 9) != 0);
                rq.template_id      = pick_id();
                rq.template_present = ($urandom_range(0, 9) != 0);
                drive_req(rq, pick_gap(), 1'b0, '0);
            end
        end

        // ---- wind down: drain, then give stray responses a chance to show ----
        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
